// ===== hw/rtl/alle_pkg.sv =====
// Package for the array linked list engine: operation and status codes,
// controller state type and default sizing. No dependencies.
package alle_pkg;

  // Default number of slots in the list stores.
  localparam int DEPTH_DEFAULT = 128;

  // Operation codes carried on the input tuser.
  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_DELETE = 2'd1;
  localparam logic [1:0] KIND_SEARCH = 2'd2;

  // Status codes carried on the output tuser.
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_FULL    = 2'd1;
  localparam logic [1:0] STATUS_MISSING = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_WALK,
    ST_FIND,
    ST_DEL_PREV,
    ST_DEL_CUR,
    ST_RESP
  } state_t;

endpackage

// ===== hw/rtl/array_linked_list_engine_top.sv =====
// Array linked list engine: value and link stores, chain walker and result register.
// Depends on alle_pkg for codes, the state type and the default depth.
//
//  channel | direction | tdata                     | tuser
//  --------+-----------+---------------------------+--------------------
//  in_     | slave     | [31:0] value (signed)     | [1:0] kind
//  out_    | master    | [6:0] slot, [7] zero      | [1:0] status
//
// Each request is taken only while the controller is idle, and it yields one
// result. The chain is walked one link per cycle through the link store read
// port: an insert walks to the tail, a search or delete to the first match or
// the end of the list, and a delete then writes back the links in ST_DEL_PREV
// and ST_DEL_CUR.
// Reset clears the head, the fill count, the control state and the output valid flag.
// The stores are not cleared: every slot below the fill count was written when
// it was allocated, and no slot at or above it is ever read.
// A result waits in the output register while the next request is accepted;
// a later result that finds the register still occupied holds the controller.
module array_linked_list_engine_top #(
  parameter int DEPTH = alle_pkg::DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic [1:0]  in_tuser,   // [1:0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [6:0] slot, [7] zero fill
  output logic [1:0]  out_tuser   // [1:0] status
);

  // Slot index width and link width; the link code DEPTH means null.
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW = $clog2(DEPTH + 1);
  localparam logic [LW-1:0] NULL_LINK = LW'(DEPTH);

  // Node stores: values and next links, each read through a registered port.
  logic [31:0]   val_mem [DEPTH];
  logic [LW-1:0] lnk_mem [DEPTH];

  alle_pkg::state_t state_r, state_nxt;

  logic [1:0]    kind_r, kind_nxt;
  logic [31:0]   key_r, key_nxt;
  logic [LW-1:0] cur_r, cur_nxt;
  logic [LW-1:0] prev_r, prev_nxt;
  logic [LW-1:0] head_r, head_nxt;
  logic [LW-1:0] used_r, used_nxt;
  logic [LW-1:0] nlink_r, nlink_nxt;
  logic [AW-1:0] slot_r, slot_nxt;
  logic [1:0]    status_r, status_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [AW-1:0] out_slot_r, out_slot_nxt;
  logic [1:0]    out_status_r, out_status_nxt;

  // Memory port controls.
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          val_we;
  logic [AW-1:0] val_wa;
  logic          lnk_we;
  logic [AW-1:0] lnk_wa;
  logic [LW-1:0] lnk_wd;
  logic [31:0]   val_q;
  logic [LW-1:0] lnk_q;

  logic          in_fire;
  logic          out_free;
  logic          head_ok;
  logic          next_ok;
  logic          hit;
  logic [AW+6:0] slot_ext;

  assign in_tready = (state_r == alle_pkg::ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign head_ok   = (head_r < NULL_LINK);
  assign next_ok   = (lnk_q < NULL_LINK);
  assign hit       = (val_q == key_r);

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      alle_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (in_tuser == alle_pkg::KIND_INSERT) begin
            if (used_r < NULL_LINK && head_ok) begin
              state_nxt = alle_pkg::ST_INS_WALK;
            end else begin
              state_nxt = alle_pkg::ST_RESP;
            end
          end else if ((in_tuser == alle_pkg::KIND_DELETE ||
                        in_tuser == alle_pkg::KIND_SEARCH) && head_ok) begin
            state_nxt = alle_pkg::ST_FIND;
          end else begin
            state_nxt = alle_pkg::ST_RESP;
          end
        end
      end
      alle_pkg::ST_INS_WALK: begin
        if (!next_ok) begin
          state_nxt = alle_pkg::ST_RESP;
        end
      end
      alle_pkg::ST_FIND: begin
        if (hit) begin
          state_nxt = (kind_r == alle_pkg::KIND_DELETE) ? alle_pkg::ST_DEL_PREV
                                                         : alle_pkg::ST_RESP;
        end else if (!next_ok) begin
          state_nxt = alle_pkg::ST_RESP;
        end
      end
      alle_pkg::ST_DEL_PREV: begin
        state_nxt = alle_pkg::ST_DEL_CUR;
      end
      alle_pkg::ST_DEL_CUR: begin
        state_nxt = alle_pkg::ST_RESP;
      end
      alle_pkg::ST_RESP: begin
        if (out_free) begin
          state_nxt = alle_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = alle_pkg::ST_IDLE;
      end
    endcase
  end

  // Datapath and memory port controls.
  always_comb begin
    kind_nxt       = kind_r;
    key_nxt        = key_r;
    cur_nxt        = cur_r;
    prev_nxt       = prev_r;
    head_nxt       = head_r;
    used_nxt       = used_r;
    nlink_nxt      = nlink_r;
    slot_nxt       = slot_r;
    status_nxt     = status_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_slot_nxt   = out_slot_r;
    out_status_nxt = out_status_r;
    rd_en          = 1'b0;
    rd_addr        = head_r[AW-1:0];
    val_we         = 1'b0;
    val_wa         = used_r[AW-1:0];
    lnk_we         = 1'b0;
    lnk_wa         = used_r[AW-1:0];
    lnk_wd         = NULL_LINK;

    unique case (state_r)
      alle_pkg::ST_IDLE: begin
        if (in_fire) begin
          kind_nxt   = in_tuser;
          key_nxt    = in_tdata;
          cur_nxt    = head_r;
          prev_nxt   = NULL_LINK;
          slot_nxt   = '0;
          status_nxt = alle_pkg::STATUS_MISSING;
          if (in_tuser == alle_pkg::KIND_INSERT) begin
            if (used_r < NULL_LINK) begin
              // Allocate the next slot and write the new tail node now.
              val_we     = 1'b1;
              lnk_we     = 1'b1;
              used_nxt   = used_r + LW'(1);
              slot_nxt   = used_r[AW-1:0];
              status_nxt = alle_pkg::STATUS_OK;
              if (head_ok) begin
                rd_en = 1'b1;
              end else begin
                head_nxt = used_r;
              end
            end else begin
              status_nxt = alle_pkg::STATUS_FULL;
            end
          end else if ((in_tuser == alle_pkg::KIND_DELETE ||
                        in_tuser == alle_pkg::KIND_SEARCH) && head_ok) begin
            rd_en = 1'b1;
          end
        end
      end
      alle_pkg::ST_INS_WALK: begin
        // The new node was written at allocation, so it is never on the walk.
        if (next_ok) begin
          cur_nxt = lnk_q;
          rd_en   = 1'b1;
          rd_addr = lnk_q[AW-1:0];
        end else begin
          lnk_we = 1'b1;
          lnk_wa = cur_r[AW-1:0];
          lnk_wd = {{(LW-AW){1'b0}}, slot_r};
        end
      end
      alle_pkg::ST_FIND: begin
        if (hit) begin
          nlink_nxt  = lnk_q;
          slot_nxt   = cur_r[AW-1:0];
          status_nxt = alle_pkg::STATUS_OK;
        end else if (next_ok) begin
          prev_nxt = cur_r;
          cur_nxt  = lnk_q;
          rd_en    = 1'b1;
          rd_addr  = lnk_q[AW-1:0];
        end
      end
      alle_pkg::ST_DEL_PREV: begin
        // Bypass the matched node: from its predecessor, or from the head.
        if (prev_r < NULL_LINK) begin
          lnk_we = 1'b1;
          lnk_wa = prev_r[AW-1:0];
          lnk_wd = nlink_r;
        end else begin
          head_nxt = nlink_r;
        end
      end
      alle_pkg::ST_DEL_CUR: begin
        lnk_we = 1'b1;
        lnk_wa = cur_r[AW-1:0];
        lnk_wd = NULL_LINK;
      end
      alle_pkg::ST_RESP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_slot_nxt   = slot_r;
          out_status_nxt = status_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= alle_pkg::ST_IDLE;
      head_r      <= NULL_LINK;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    key_r        <= key_nxt;
    cur_r        <= cur_nxt;
    prev_r       <= prev_nxt;
    nlink_r      <= nlink_nxt;
    slot_r       <= slot_nxt;
    status_r     <= status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_status_r <= out_status_nxt;
  end

  // Value store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (val_we) begin
      val_mem[val_wa] <= key_nxt;
    end
    if (rd_en) begin
      val_q <= val_mem[rd_addr];
    end
  end

  // Link store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (lnk_we) begin
      lnk_mem[lnk_wa] <= lnk_wd;
    end
    if (rd_en) begin
      lnk_q <= lnk_mem[rd_addr];
    end
  end

  assign slot_ext   = {7'b0, out_slot_r};
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, slot_ext[6:0]};
  assign out_tuser  = out_status_r;

  // The fill count never passes the number of slots.
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= NULL_LINK)
    else $error("fill count beyond depth");

  // A non-empty list has its head among the allocated slots.
  a_head_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    (head_r != NULL_LINK) |-> (head_r < used_r))
    else $error("head outside allocated slots");

  // The walk only visits allocated slots.
  a_walk_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == alle_pkg::ST_FIND || state_r == alle_pkg::ST_INS_WALK)
      |-> (cur_r < used_r))
    else $error("walk left allocated slots");

  // A finished request loads the output register once it is free.
  a_resp_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == alle_pkg::ST_RESP && out_free) |=> out_valid_r)
    else $error("result not presented");

endmodule

// ===== tb/array_linked_list_engine_top_tb.sv =====
// Self-checking testbench for the array linked list engine: directed and random
// insert, delete and search requests, checked against a behavioral list model.
// Depends on alle_pkg and array_linked_list_engine_top.
module array_linked_list_engine_top_tb;

  localparam int DEPTH = alle_pkg::DEPTH_DEFAULT;
  // The fourth kind code has no operation behind it; the engine must answer
  // "not found" and leave the list alone.
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  // Cycles with no handshake on either channel before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 20 * DEPTH;
  localparam int POOL_SIZE = 16;

  typedef struct packed {
    logic [1:0] status;
    logic [6:0] slot;
  } list_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;   // [31:0] value
  logic [1:0]  in_tuser = '0;   // [1:0] kind
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;       // [6:0] slot, [7] zero fill
  logic [1:0]  out_tuser;       // [1:0] status

  // Behavioral copy of the list: node values, next links (DEPTH means null),
  // the head pointer and the bump allocator count.
  logic [31:0]  node_value [DEPTH];
  int           node_link  [DEPTH];
  int           list_head;
  int           slots_taken;

  list_result_t pending_results[$];
  logic [31:0]  value_pool[POOL_SIZE];
  int           mismatch_count = 0;
  int           quiet_cycles = 0;
  // When set, neither side inserts idle cycles.
  bit           no_stall = 1'b0;

  array_linked_list_engine_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Applies one operation to the list copy and returns the answer the engine
  // owes for it.
  function automatic list_result_t apply_list_op(input logic [1:0] kind,
                                                 input logic [31:0] value);
    list_result_t res;
    int prev;
    int cur;
    int steps;
    bit found;
    res.status = alle_pkg::STATUS_MISSING;
    res.slot = '0;
    prev = DEPTH;
    cur = list_head;
    found = 1'b0;
    case (kind) inside
      alle_pkg::KIND_INSERT: begin
        if (slots_taken >= DEPTH) begin
          res.status = alle_pkg::STATUS_FULL;
        end else begin
          node_value[slots_taken] = value;
          node_link[slots_taken] = DEPTH;
          if (list_head >= DEPTH) begin
            list_head = slots_taken;
          end else begin
            // Walk to the tail and hang the new node behind it.
            cur = list_head;
            steps = 0;
            while (steps < DEPTH && node_link[cur] < DEPTH) begin
              cur = node_link[cur];
              steps++;
            end
            node_link[cur] = slots_taken;
          end
          res.status = alle_pkg::STATUS_OK;
          res.slot = slots_taken[6:0];
          slots_taken++;
        end
      end
      alle_pkg::KIND_DELETE, alle_pkg::KIND_SEARCH: begin
        // The first match in list order wins, which matters for duplicates.
        for (steps = 0; steps < DEPTH && cur < DEPTH && !found; steps++) begin
          if (node_value[cur] == value) begin
            found = 1'b1;
          end else begin
            prev = cur;
            cur = node_link[cur];
          end
        end
        if (found) begin
          if (kind == alle_pkg::KIND_DELETE) begin
            if (prev < DEPTH) begin
              node_link[prev] = node_link[cur];
            end else begin
              list_head = node_link[cur];
            end
            node_link[cur] = DEPTH;
          end
          res.status = alle_pkg::STATUS_OK;
          res.slot = cur[6:0];
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  // Mostly values from a small pool, so duplicates and repeat hits are common.
  function automatic logic [31:0] pick_value();
    if ($urandom_range(0, 99) < 75) begin
      return value_pool[$urandom_range(0, POOL_SIZE - 1)];
    end
    return $urandom;
  endfunction

  // Half the time a value that is on the list right now, so deletes and
  // searches hit nodes at every position of the chain.
  function automatic logic [31:0] pick_target_value();
    int length;
    int pick;
    int cur;
    length = 0;
    cur = list_head;
    while (cur < DEPTH && length < DEPTH) begin
      length++;
      cur = node_link[cur];
    end
    if (length == 0 || $urandom_range(0, 1) == 0) begin
      return pick_value();
    end
    pick = $urandom_range(0, length - 1);
    cur = list_head;
    repeat (pick) cur = node_link[cur];
    return node_value[cur];
  endfunction

  // Presents one request at a falling edge, possibly after some idle cycles,
  // and holds it until the engine takes it at a rising edge.
  task automatic send_request(input logic [1:0] kind, input logic [31:0] value);
    @(negedge clk);
    while (!no_stall && $urandom_range(0, 99) < 12) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= value;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.push_back(apply_list_op(kind, value));
  endtask

  // Holds the sender back until every outstanding result has come out.
  task automatic wait_for_drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Random operation mix; the insert share decides whether the list grows.
  task automatic send_random_op(input int insert_pct, input int search_pct,
                                input int delete_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < insert_pct) begin
      send_request(alle_pkg::KIND_INSERT, pick_value());
    end else if (roll < insert_pct + search_pct) begin
      send_request(alle_pkg::KIND_SEARCH, pick_target_value());
    end else if (roll < insert_pct + search_pct + delete_pct) begin
      send_request(alle_pkg::KIND_DELETE, pick_target_value());
    end else begin
      send_request(KIND_UNUSED, $urandom);
    end
  endtask

  // Delete and search on an empty list, and the unused kind.
  task automatic test_empty_list();
    send_request(alle_pkg::KIND_SEARCH, 32'h0000_0000);
    send_request(alle_pkg::KIND_DELETE, 32'h7fff_ffff);
    send_request(KIND_UNUSED, 32'h0000_0000);
  endtask

  // Extreme values, duplicates, and deletes at the head, middle and tail.
  task automatic test_value_extremes();
    send_request(alle_pkg::KIND_INSERT, 32'h8000_0000);
    send_request(alle_pkg::KIND_INSERT, 32'h7fff_ffff);
    send_request(alle_pkg::KIND_INSERT, 32'h0000_0000);
    send_request(alle_pkg::KIND_INSERT, 32'hffff_ffff);
    send_request(alle_pkg::KIND_INSERT, 32'h7fff_ffff);
    send_request(alle_pkg::KIND_SEARCH, 32'h7fff_ffff);
    send_request(alle_pkg::KIND_SEARCH, 32'hffff_ffff);
    send_request(alle_pkg::KIND_SEARCH, 32'h1234_5678);
    send_request(alle_pkg::KIND_DELETE, 32'h8000_0000);
    send_request(alle_pkg::KIND_DELETE, 32'h7fff_ffff);
    send_request(alle_pkg::KIND_SEARCH, 32'h7fff_ffff);
    send_request(alle_pkg::KIND_DELETE, 32'hffff_ffff);
    send_request(alle_pkg::KIND_DELETE, 32'h7fff_ffff);
    send_request(alle_pkg::KIND_DELETE, 32'h7fff_ffff);
    send_request(KIND_UNUSED, 32'hffff_ffff);
    send_request(alle_pkg::KIND_INSERT, 32'h5555_aaaa);
    send_request(alle_pkg::KIND_SEARCH, 32'h5555_aaaa);
  endtask

  // Grows the list until every slot is consumed, with searches and deletes
  // mixed in so that deleted slots are left behind in the allocation order.
  task automatic test_fill_list();
    while (slots_taken < DEPTH) begin
      send_random_op(55, 20, 20);
    end
  endtask

  // With the allocator exhausted, inserts must report full while searches
  // and deletes keep working on what is left. The middle stretch runs with
  // no idle cycles on either side.
  task automatic test_full_list(input int count);
    for (int i = 0; i < count; i++) begin
      no_stall = (i >= 150 && i < 300);
      send_random_op(10, 55, 30);
    end
    no_stall = 1'b0;
  endtask

  // The receiver stalls about 12 percent of the time, unless no_stall is set.
  always @(negedge clk) begin
    out_tready <= rst_n && (no_stall || $urandom_range(0, 99) >= 12);
  end

  // Each result is checked against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("Unexpected result: status %0d slot %0d", out_tuser, out_tdata[6:0]);
        end
      end else begin
        if (out_tuser !== pending_results[0].status ||
            out_tdata !== {1'b0, pending_results[0].slot}) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("Mismatch: expected status %0d tdata 0x%02h, got status %0d tdata 0x%02h",
                     pending_results[0].status, {1'b0, pending_results[0].slot},
                     out_tuser, out_tdata);
          end
        end
        void'(pending_results.pop_front());
      end
    end
  end

  // Watchdog: ends the run if neither channel moves for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < DEPTH; i++) begin
      node_value[i] = '0;
      node_link[i] = DEPTH;
    end
    list_head = DEPTH;
    slots_taken = 0;
    value_pool[0] = 32'h8000_0000;
    value_pool[1] = 32'h7fff_ffff;
    value_pool[2] = 32'h0000_0000;
    value_pool[3] = 32'hffff_ffff;
    for (int i = 4; i < POOL_SIZE; i++) begin
      value_pool[i] = $urandom;
    end

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    test_empty_list();
    test_value_extremes();
    test_fill_list();
    wait_for_drain();
    test_full_list(700);

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DEPTH + 10) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/alle_pkg.sv
hw/rtl/array_linked_list_engine_top.sv
tb/array_linked_list_engine_top_tb.sv
